// ===== rtl/lspfe_pkg.sv =====
// Package for the LED strip pattern frame engine: types, codes, tables and helpers.
`default_nettype none
package lspfe_pkg;

  localparam int unsigned MaxLedsDef = 64;
  localparam int unsigned LenW       = 7;   // strip_length width, also holds the count
  localparam int unsigned NumW       = 6;   // led_number / pixel_index width
  localparam int unsigned ColorW     = 24;
  localparam int unsigned CfgW       = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned TimeW      = 64;
  localparam int unsigned StepW      = 32;
  localparam int unsigned PatW       = 4;

  localparam logic [31:0] LfsrTaps = 32'h8020_0003;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_LEN  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PAT  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INTV = 2'd2;

  // pattern codes
  localparam logic [PatW-1:0] PAT_RED     = 4'd0;
  localparam logic [PatW-1:0] PAT_GREEN   = 4'd1;
  localparam logic [PatW-1:0] PAT_BLUE    = 4'd2;
  localparam logic [PatW-1:0] PAT_CHASE   = 4'd3;
  localparam logic [PatW-1:0] PAT_SPARKLE = 4'd4;
  localparam logic [PatW-1:0] PAT_RANDOM  = 4'd5;
  localparam logic [PatW-1:0] PAT_ALT     = 4'd6;
  localparam logic [PatW-1:0] PAT_PULSE   = 4'd7;
  localparam logic [PatW-1:0] PAT_WIPE    = 4'd8;
  localparam logic [PatW-1:0] PAT_RAINBOW = 4'd9;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SHOW  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_RENDER,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [6:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] rem;
  } mod_rsp_t;

  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    logic [31:0] r;
    r = s >> 1;
    if (s[0]) r = r ^ LfsrTaps;
    return r;
  endfunction

  // 64 == 1 mod 9: summing 6-bit digits keeps the residue, result 0..66
  function automatic logic [6:0] step_fold9(input logic [31:0] s);
    logic [8:0] s9;
    logic [6:0] f;
    s9 = 9'(s[5:0]) + 9'(s[11:6]) + 9'(s[17:12]) + 9'(s[23:18]) +
         9'(s[29:24]) + 9'(s[31:30]);
    f  = 7'(s9[8:6]) + 7'(s9[5:0]);
    return f;
  endfunction

  // residue mod 9 of a folded value 0..67
  function automatic logic [3:0] fold9_mod(input logic [6:0] x);
    logic [6:0] v;
    v = x;
    if (v >= 7'd36) v = v - 7'd36;
    if (v >= 7'd18) v = v - 7'd18;
    if (v >= 7'd9)  v = v - 7'd9;
    return v[3:0];
  endfunction

  function automatic logic [7:0] pulse_level(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0: v = 8'd20;
      3'd1: v = 8'd60;
      3'd2: v = 8'd100;
      3'd3: v = 8'd140;
      3'd4: v = 8'd180;
      3'd5: v = 8'd220;
      3'd6: v = 8'd180;
      default: v = 8'd140;
    endcase
    return v;
  endfunction

  function automatic logic [ColorW-1:0] rainbow_color(input logic [3:0] k);
    logic [ColorW-1:0] c;
    case (k)
      4'd0: c = 24'h00ff00;
      4'd1: c = 24'h40ff00;
      4'd2: c = 24'h80ff00;
      4'd3: c = 24'hff0000;
      4'd4: c = 24'hff0080;
      4'd5: c = 24'h8000ff;
      4'd6: c = 24'h0000ff;
      4'd7: c = 24'h0080ff;
      default: c = 24'h00ff80;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lspfe_fbuf.sv =====
// Frame buffer: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module lspfe_fbuf #(
  parameter int unsigned Depth = lspfe_pkg::MaxLedsDef,
  parameter int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [lspfe_pkg::ColorW-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [lspfe_pkg::ColorW-1:0] rdata_o
);
  import lspfe_pkg::*;

  logic [ColorW-1:0] mem [Depth];
  logic [Depth-1:0]  vld_q;
  logic [ColorW-1:0] rd_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= 1'b1;
      if (re_i) rvld_q <= vld_q[raddr_i];
    end
  end

  // never-written entries read as black
  assign rdata_o = rvld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/lspfe_mod.sv =====
// Iterative 32-bit by 7-bit remainder unit, one quotient bit per cycle.
`default_nettype none
module lspfe_mod (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lspfe_pkg::mod_req_t req_i,
  output lspfe_pkg::mod_rsp_t      rsp_o
);
  import lspfe_pkg::*;

  logic [31:0] dvd_q;
  logic [6:0]  div_q, rem_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [7:0]  sh;

  assign sh = {rem_q, dvd_q[31]};

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= dvd_q << 1;
      if (sh >= {1'b0, div_q}) rem_q <= 7'(sh - {1'b0, div_q});
      else                     rem_q <= sh[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= 6'd32;
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/led_strip_pattern_frame_engine_core.sv =====
// Top level of the LED strip pattern frame engine.
`default_nettype none
// One request at a time: start is taken when busy is low. A pixel write
// finishes in its accept cycle and gives no result. A show streams the
// buffer, one pixel per cycle, each result registered from the buffer read.
// A firing tick renders one pixel per cycle into the frame buffer, then
// streams it as for a show. Chase, sparkle and wipe first run the shared
// remainder unit; rainbow first reduces the step mod 9 in the remainder
// state. An unknown pattern streams at once like a show. Results appear
// for exactly one cycle each with result_strobe_o high; the receiver
// cannot stall them. A tick that does not fire, or opcode 3, leaves the
// block idle and gives no result. No clearing pass after reset.
module led_strip_pattern_frame_engine_core #(
  parameter int unsigned MAX_LEDS = lspfe_pkg::MaxLedsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [lspfe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lspfe_pkg::CfgW-1:0]    cfg_data_i,
  // request
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [lspfe_pkg::TimeW-1:0]   time_now_i,
  input  wire logic [lspfe_pkg::NumW-1:0]    pixel_index_i,
  input  wire logic [7:0]                    red_level_i,
  input  wire logic [7:0]                    green_level_i,
  input  wire logic [7:0]                    blue_level_i,
  // results
  output logic                               result_strobe_o,
  output logic [lspfe_pkg::NumW-1:0]         led_number_o,
  output logic [lspfe_pkg::ColorW-1:0]       color_word_o,
  output logic                               frame_end_o
);
  import lspfe_pkg::*;

  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_LEDS);

  // configuration registers
  logic [LenW-1:0]  len_q;
  logic [PatW-1:0]  pat_q;
  logic [31:0]      intv_q;

  // block state
  logic [StepW-1:0] step_q;
  logic [TimeW-1:0] last_q;
  logic [31:0]      seed_q;

  state_e           state_q, state_d;
  logic [LenW-1:0]  idx_q;       // render / emit position
  logic [6:0]       hit_q;       // remainder result
  logic [3:0]       phase_q;     // rainbow phase
  logic [31:0]      sum_q;       // step + 3*i, wrapped
  logic [6:0]       fold_q;      // step folded mod 9, 0..66
  logic             out_vld_q, out_last_q;
  logic [NumW-1:0]  out_num_q;

  logic [LenW-1:0]  n;
  logic             accept, fire, is_tick, uses_mod, known_pat, last_idx;
  logic [TimeW-1:0] elapsed;
  logic [31:0]      draw1, rs1, rs2, rs3;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [ColorW-1:0] mem_wdata, render_px, mem_rdata;

  // effective length: 0 acts as 1, above MAX_LEDS clamps
  always_comb begin
    if (len_q == '0)         n = LenW'(1);
    else if (len_q > MaxLen) n = MaxLen;
    else                     n = len_q;
  end

  assign accept    = start_i && (state_q == ST_IDLE);
  assign is_tick   = (opcode_i == OP_TICK);
  assign elapsed   = time_now_i - last_q;
  assign fire      = is_tick && (intv_q != '0) && !(elapsed < {32'b0, intv_q});
  assign uses_mod  = (pat_q == PAT_CHASE) || (pat_q == PAT_SPARKLE) ||
                     (pat_q == PAT_WIPE);
  assign known_pat = (pat_q <= PAT_RAINBOW);
  assign last_idx  = (idx_q == n - LenW'(1));
  assign draw1     = lfsr_next(seed_q);
  assign rs1       = lfsr_next(seed_q);
  assign rs2       = lfsr_next(rs1);
  assign rs3       = lfsr_next(rs2);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_SHOW) begin
            state_d = ST_EMIT;
          end else if (fire) begin
            if (!known_pat)                            state_d = ST_EMIT;
            else if (uses_mod || pat_q == PAT_RAINBOW) state_d = ST_MOD;
            else                                       state_d = ST_RENDER;
          end
        end
      end
      ST_MOD:    if (mod_rsp.done || (pat_q == PAT_RAINBOW)) state_d = ST_RENDER;
      ST_RENDER: if (last_idx) state_d = ST_EMIT;
      ST_EMIT:   if (last_idx) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // pixel value for the current render position
  always_comb begin
    render_px = '0;
    case (pat_q)
      PAT_RED:     render_px = 24'h00ff00;
      PAT_GREEN:   render_px = 24'hff0000;
      PAT_BLUE:    render_px = 24'h0000ff;
      PAT_CHASE:   render_px = (idx_q == hit_q) ? 24'h80ff00 : 24'h101010;
      PAT_SPARKLE: render_px = (idx_q == hit_q) ? 24'hffffff : 24'h000000;
      PAT_RANDOM:  render_px = {rs2[7:0], rs1[7:0], rs3[7:0]};
      PAT_ALT:     render_px = idx_q[0] ? 24'hff00ff : 24'h00ffff;
      PAT_PULSE:   render_px = {8'h10, pulse_level(step_q[2:0]),
                                pulse_level(step_q[2:0])};
      PAT_WIPE:    render_px = (idx_q < hit_q) ? 24'h8000ff : 24'h000000;
      PAT_RAINBOW: render_px = rainbow_color(phase_q);
      default:     render_px = '0;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy_o           = (state_q != ST_IDLE);
    mem_we           = 1'b0;
    mem_waddr        = idx_q[AW-1:0];
    mem_wdata        = render_px;
    mem_re           = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = step_q;
    mod_req.divisor  = n;
    case (pat_q)
      PAT_SPARKLE: mod_req.dividend = draw1;
      PAT_WIPE:    mod_req.divisor  = n + LenW'(1);
      default:     ;
    endcase
    case (state_q)
      ST_IDLE: begin
        if (accept && (opcode_i == OP_WRITE) && ({1'b0, pixel_index_i} < n)) begin
          mem_we    = 1'b1;
          mem_waddr = pixel_index_i[AW-1:0];
          mem_wdata = {green_level_i, red_level_i, blue_level_i};
        end
        mod_req.start = accept && fire && known_pat && uses_mod;
      end
      ST_RENDER: mem_we = 1'b1;
      ST_EMIT:   mem_re = 1'b1;
      default:   ;
    endcase
  end

  // rainbow phase advance: +3 mod 9, and -2^32 (== -4 mod 9) on wrap
  logic [32:0] sum_nx;
  logic [3:0]  ph3, ph_nx;
  always_comb begin
    sum_nx = {1'b0, sum_q} + 33'd3;
    ph3    = (phase_q + 4'd3 >= 4'd9) ? phase_q + 4'd3 - 4'd9 : phase_q + 4'd3;
    ph_nx  = ph3;
    if (sum_nx[32]) ph_nx = (ph3 + 4'd5 >= 4'd9) ? ph3 + 4'd5 - 4'd9 : ph3 + 4'd5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      len_q      <= LenW'(8);
      pat_q      <= PAT_GREEN;
      intv_q     <= '0;
      step_q     <= '0;
      last_q     <= '0;
      seed_q     <= 32'd1;
      idx_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LEN:  len_q <= cfg_data_i[LenW-1:0];
          REG_PAT: begin
            pat_q  <= cfg_data_i[PatW-1:0];
            step_q <= '0;
            last_q <= '0;
          end
          REG_INTV: intv_q <= cfg_data_i;
          default:  ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (accept && fire) begin
            last_q <= time_now_i;
            if (pat_q == PAT_SPARKLE) seed_q <= draw1;
            if (!known_pat) step_q <= step_q + 32'd1;
          end
        end
        ST_RENDER: begin
          if (pat_q == PAT_RANDOM) seed_q <= rs3;
          if (last_idx) begin
            idx_q  <= '0;
            step_q <= step_q + 32'd1;
          end else begin
            idx_q <= idx_q + LenW'(1);
          end
        end
        ST_EMIT: begin
          out_vld_q  <= 1'b1;
          out_last_q <= last_idx;
          idx_q      <= idx_q + LenW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fold_q <= step_fold9(step_q);
    if (state_q == ST_EMIT) out_num_q <= idx_q[NumW-1:0];
    if (mod_rsp.done) begin
      hit_q   <= mod_rsp.rem;
      phase_q <= mod_rsp.rem[3:0];
      sum_q   <= step_q;
    end else if ((state_q == ST_MOD) && (pat_q == PAT_RAINBOW)) begin
      phase_q <= fold9_mod(fold_q);
      sum_q   <= step_q;
    end else if (state_q == ST_RENDER) begin
      phase_q <= ph_nx;
      sum_q   <= sum_nx[31:0];
    end
  end

  lspfe_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  lspfe_fbuf #(
    .Depth (MAX_LEDS),
    .AW    (AW)
  ) u_fbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign result_strobe_o = out_vld_q;
  assign led_number_o    = out_num_q;
  assign color_word_o    = mem_rdata;
  assign frame_end_o     = out_vld_q && out_last_q;

`ifndef SYNTHESIS
  a_strobe_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $past(state_q == ST_EMIT)) else $error("strobe outside emit");
  a_render_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RENDER || state_q == ST_EMIT) |-> idx_q < n)
    else $error("position beyond strip");
  a_frame_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end_o |-> ({1'b0, led_number_o} == n - LenW'(1)))
    else $error("frame end not on last pixel");
  a_mod_only_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> state_q == ST_MOD) else $error("remainder without waiter");
`endif

endmodule
`default_nettype wire

// ===== dv/led_strip_pattern_frame_engine_core_tb.sv =====
// Self-checking testbench for the LED strip pattern frame engine core.
`timescale 1ns / 1ps
module led_strip_pattern_frame_engine_core_tb;
  import lspfe_pkg::*;

  // request fields as the driver sees them
  typedef struct {
    logic [1:0]  op;
    logic [63:0] now;
    logic [5:0]  idx;
    logic [7:0]  r, g, b;
  } strip_req_t;

  // one emitted pixel
  typedef struct {
    logic [5:0]  num;
    logic [23:0] color;
    logic        last;
  } pixel_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  opcode_i = '0;
  logic [63:0] time_now_i = '0;
  logic [5:0]  pixel_index_i = '0;
  logic [7:0]  red_level_i = '0, green_level_i = '0, blue_level_i = '0;
  logic        result_strobe_o;
  logic [5:0]  led_number_o;
  logic [23:0] color_word_o;
  logic        frame_end_o;

  always #1 clk_i = ~clk_i;

  led_strip_pattern_frame_engine_core uut (.*);

  // shadow state of the engine
  logic [23:0] pix_buf [64];
  logic [31:0] step_q;
  logic [63:0] last_time_q;
  logic [31:0] lfsr_q;
  logic [6:0]  len_q;
  logic [3:0]  pat_q;
  logic [31:0] intv_q;

  strip_req_t pending_reqs[$];
  pixel_out_t expected_pixels[$];
  int mismatches = 0;
  int n_results = 0;
  int n_fired = 0;
  int n_reqs = 0;
  bit stim_done = 0;

  function automatic logic [23:0] to_grb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {g, r, b};
  endfunction

  function automatic logic [31:0] lfsr_draw();
    logic lsb;
    lsb = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (lsb) lfsr_q = lfsr_q ^ 32'h8020_0003;
    return lfsr_q;
  endfunction

  function automatic int unsigned strip_len();
    if (len_q == 0) return 1;
    if (len_q > 64) return 64;
    return len_q;
  endfunction

  // draw the selected pattern into the shadow buffer
  function automatic void paint_frame(int unsigned n);
    logic [31:0] hit, lv, rv, gv, bv, ph;
    logic [23:0] rainbow [9];
    rainbow = '{24'h00ff00, 24'h40ff00, 24'h80ff00, 24'hff0000, 24'hff0080,
                24'h8000ff, 24'h0000ff, 24'h0080ff, 24'h00ff80};
    case (pat_q)
      PAT_RED:   for (int i = 0; i < n; i++) pix_buf[i] = to_grb(8'hff, 0, 0);
      PAT_GREEN: for (int i = 0; i < n; i++) pix_buf[i] = to_grb(0, 8'hff, 0);
      PAT_BLUE:  for (int i = 0; i < n; i++) pix_buf[i] = to_grb(0, 0, 8'hff);
      PAT_CHASE: begin
        hit = step_q % n;
        for (int i = 0; i < n; i++)
          pix_buf[i] = (i == hit) ? to_grb(8'hff, 8'h80, 0) : to_grb(8'h10, 8'h10, 8'h10);
      end
      PAT_SPARKLE: begin
        for (int i = 0; i < n; i++) pix_buf[i] = '0;
        hit = lfsr_draw() % n;
        pix_buf[hit] = 24'hffffff;
      end
      PAT_RANDOM: begin
        for (int i = 0; i < n; i++) begin
          rv = lfsr_draw();
          gv = lfsr_draw();
          bv = lfsr_draw();
          pix_buf[i] = to_grb(rv[7:0], gv[7:0], bv[7:0]);
        end
      end
      PAT_ALT:
        for (int i = 0; i < n; i++)
          pix_buf[i] = i[0] ? to_grb(0, 8'hff, 8'hff) : to_grb(8'hff, 0, 8'hff);
      PAT_PULSE: begin
        case (step_q[2:0])
          3'd0: lv = 20;  3'd1: lv = 60;  3'd2: lv = 100; 3'd3: lv = 140;
          3'd4: lv = 180; 3'd5: lv = 220; 3'd6: lv = 180; default: lv = 140;
        endcase
        for (int i = 0; i < n; i++) pix_buf[i] = to_grb(lv[7:0], 8'h10, lv[7:0]);
      end
      PAT_WIPE: begin
        hit = step_q % (n + 1);
        for (int i = 0; i < n; i++) pix_buf[i] = (i < hit) ? to_grb(0, 8'h80, 8'hff) : '0;
      end
      PAT_RAINBOW:
        for (int i = 0; i < n; i++) begin
          ph = step_q + 32'(i * 3);
          pix_buf[i] = rainbow[ph % 9];
        end
      default: ;
    endcase
  endfunction

  function automatic void queue_frame(int unsigned n);
    pixel_out_t p;
    for (int i = 0; i < n; i++) begin
      p.num = i[5:0];
      p.color = pix_buf[i];
      p.last = (i + 1 == n);
      expected_pixels.push_back(p);
    end
  endfunction

  // work out the pixels one request causes
  function automatic void predict_request(strip_req_t q);
    int unsigned n;
    n = strip_len();
    case (q.op)
      OP_TICK:
        if (intv_q != 0 && (q.now - last_time_q) >= {32'h0, intv_q}) begin
          last_time_q = q.now;
          paint_frame(n);
          queue_frame(n);
          step_q++;
          n_fired++;
        end
      OP_WRITE: if (q.idx < n) pix_buf[q.idx] = to_grb(q.r, q.g, q.b);
      OP_SHOW: queue_frame(n);
      default: ;
    endcase
  endfunction

  // driver: one request at a time from the pending queue, random gaps
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_request(pending_reqs.pop_front());
        n_reqs++;
        start_i <= 1'b0;
        gap = $urandom_range(0, 11);
      end else if (!start_i && pending_reqs.size() > 0) begin
        if (gap > 0) gap--;
        else begin
          start_i <= 1'b1;
          opcode_i <= pending_reqs[0].op;
          time_now_i <= pending_reqs[0].now;
          pixel_index_i <= pending_reqs[0].idx;
          red_level_i <= pending_reqs[0].r;
          green_level_i <= pending_reqs[0].g;
          blue_level_i <= pending_reqs[0].b;
        end
      end
    end
  end

  // monitor: every strobed pixel against the oldest expectation
  always @(posedge clk_i) begin
    pixel_out_t e;
    if (rst_ni && result_strobe_o) begin
      n_results++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %0d color %06h", led_number_o, color_word_o);
      end else begin
        e = expected_pixels.pop_front();
        if (e.num !== led_number_o || e.color !== color_word_o || e.last !== frame_end_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: exp %0d %06h %0b got %0d %06h %0b",
                     e.num, e.color, e.last, led_number_o, color_word_o, frame_end_o);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LEN: len_q = val[6:0];
      REG_PAT: begin
        pat_q = val[3:0];
        step_q = 0;
        last_time_q = 0;
      end
      default: intv_q = val;
    endcase
  endtask

  // drain: wait until all requests are taken and all pixels seen, then settle
  task automatic drain();
    wait (pending_reqs.size() == 0 && !start_i);
    @(posedge clk_i);
    wait (!busy_o && expected_pixels.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic strip_req_t mk(logic [1:0] op, logic [63:0] now, logic [5:0] idx,
                                    logic [7:0] r, logic [7:0] g, logic [7:0] b);
    strip_req_t q;
    q.op = op; q.now = now; q.idx = idx; q.r = r; q.g = g; q.b = b;
    return q;
  endfunction

  function automatic strip_req_t rand_req(logic [63:0] now);
    int k;
    k = $urandom_range(0, 9);
    return mk(k < 5 ? OP_TICK : k < 8 ? OP_WRITE : k < 9 ? OP_SHOW : OP_NONE,
              now, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  initial begin
    logic [63:0] tnow;
    logic [6:0] lens [4];
    for (int i = 0; i < 64; i++) pix_buf[i] = '0;
    step_q = 0; last_time_q = 0; lfsr_q = 1;
    len_q = 8; pat_q = PAT_GREEN; intv_q = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset defaults, disabled ticks, writes in and out of range, opcode 3
    pending_reqs.push_back(mk(OP_SHOW, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_TICK, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_WRITE, 0, 0, 8'hff, 8'h00, 8'hff));
    pending_reqs.push_back(mk(OP_WRITE, 0, 7, 8'h00, 8'hff, 8'h00));
    pending_reqs.push_back(mk(OP_WRITE, 0, 8, 8'h12, 8'h34, 8'h56));
    pending_reqs.push_back(mk(OP_WRITE, 0, 63, 8'hff, 8'hff, 8'hff));
    pending_reqs.push_back(mk(OP_NONE, 64'hffff_ffff_ffff_ffff, 63, 8'hff, 8'hff, 8'hff));
    pending_reqs.push_back(mk(OP_SHOW, 0, 0, 0, 0, 0));
    drain();
    // length 0 acts as 1, max interval, wrapped time difference
    write_reg(REG_LEN, 0);
    write_reg(REG_INTV, 32'hffff_ffff);
    pending_reqs.push_back(mk(OP_TICK, 64'hffff_fffe, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_TICK, 64'hffff_ffff, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_TICK, 64'h0, 0, 0, 0, 0));
    drain();
    // length above max acts as max; every pattern fires twice, plus unknown ones
    write_reg(REG_LEN, 7'd127);
    write_reg(REG_INTV, 1);
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_PAT, p == 11 ? 15 : p);
      pending_reqs.push_back(mk(OP_TICK, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0));
      pending_reqs.push_back(mk(OP_TICK, 64'h1, 0, 0, 0, 0));
      drain();
    end

    // random phases over several settings
    lens = '{7'd1, 7'd5, 7'd64, 7'd13};
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_LEN, ph % 4 == 2 ? 7'd64 : 7'($urandom_range(1, 16)));
      if (ph % 4 == 0) write_reg(REG_LEN, lens[ph / 4]);
      write_reg(REG_PAT, $urandom_range(0, 10));
      write_reg(REG_INTV, ph == 5 ? 32'h0 : ph == 7 ? $urandom : $urandom_range(1, 20));
      // step counter near wrap is out of reach; time jumps cover bits of time_now
      tnow = {$urandom, $urandom} >> $urandom_range(0, 60);
      for (int k = 0; k < 10; k++) begin
        tnow = tnow + $urandom_range(0, 25);
        if ($urandom_range(0, 15) == 0) tnow = {$urandom, $urandom};
        pending_reqs.push_back(rand_req(tnow));
      end
      drain();
    end
    stim_done = 1;
    $display("Covered %0d requests, %0d firing ticks, %0d pixels checked.",
             n_reqs, n_fired, n_results);
    $display("All patterns, length extremes and interval settings exercised.");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
